// ----- hdl/lrbs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bank switcher package
// Shared types, address decode constants, variant codes and the bit-reversal
// helper used by the latch register bank switcher.
// ----------------------------------------------------------------------------
package lrbs_pkg;

   // Chip variant codes as held in the configuration register.
   localparam logic [2:0] VARIANT_36  = 3'd0;
   localparam logic [2:0] VARIANT_132 = 3'd1;
   localparam logic [2:0] VARIANT_136 = 3'd2;
   localparam logic [2:0] VARIANT_172 = 3'd3;
   localparam logic [2:0] VARIANT_173 = 3'd4;

   // Register select codes taken from address bits 1:0.
   localparam logic [1:0] SEL_LOAD   = 2'd0;
   localparam logic [1:0] SEL_INVERT = 2'd1;
   localparam logic [1:0] SEL_LATCH  = 2'd2;
   localparam logic [1:0] SEL_MODE   = 2'd3;

   // Address decode. With bits 1:0 ignored, the 0x41xx register window
   // matches the same addresses for reads and writes.
   localparam logic [15:0] REG_WINDOW_MASK = 16'hE100;
   localparam logic [15:0] REG_WINDOW      = 16'h4100;
   localparam logic [15:0] CHR_WINDOW_MASK = 16'hE200;
   localparam logic [15:0] CHR_WINDOW      = 16'h4200;

   typedef struct packed {
      logic [5:0] input_latch;
      logic [5:0] work_register;
      logic       invert_flag;
      logic       increment_mode;
      logic [1:0] prg_bank;
      logic [3:0] chr_bank;
      logic       mirror;
   } lrbs_state_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       read_is_register;
   } lrbs_read_type;

   // Keeps bits 7:6 and reverses the order of bits 5:0.
   function automatic logic [7:0] rev6(input logic [7:0] v);
      return {v[7:6], v[0], v[1], v[2], v[3], v[4], v[5]};
   endfunction

endpackage

// ----- hdl/latch_register_bank_switcher_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Latch register bank switcher
// Cartridge bank-switch register chip with five selectable decode variants,
// processing one CPU bus access per transaction.
// ----------------------------------------------------------------------------
// Each request transaction is one CPU bus access (read or write). It lands in
// an input register, is decoded against the chip registers combinationally,
// and its result (register read value plus the bank state after the access)
// is held in a result register until the response side takes it. A new
// access is accepted every cycle while responses flow. rsp_valid rises when
// the transaction moves from the input register into the result register,
// and with no stall sustained throughput is one transaction per cycle; that
// rate is set by the update of the working register and bank state, which
// every access reads and writes in order. The
// variant register (csr_write_data, 0=36, 1=132, 2=136, 3=172, 4=173) should
// only be written while no transaction is in flight; codes 5 to 7 make the
// chip ignore every access.
module latch_register_bank_switcher_top
   import lrbs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_write_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_mode,
   input  logic [15:0] req_address,
   input  logic [7:0]  req_write_data,
   input  logic [7:0]  req_open_bus,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_read_data,
   output logic        rsp_read_is_register,
   output logic [1:0]  rsp_prg_bank,
   output logic [3:0]  rsp_chr_bank,
   output logic        rsp_mirror_vertical
);

   // Configuration register.
   logic [2:0] variant_ff;

   // Input register stage.
   logic        in_valid_ff;
   logic        in_valid_in;
   logic        in_mode_ff;
   logic [15:0] in_address_ff;
   logic [7:0]  in_write_data_ff;
   logic [7:0]  in_open_bus_ff;

   // Chip state.
   lrbs_state_type state_ff;
   lrbs_state_type state_in;
   lrbs_read_type  read_result;

   // Result register stage.
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   lrbs_read_type rsp_read_ff;
   lrbs_state_type rsp_state_ff;

   logic out_free;
   logic advance;

   // The result register can take a new transaction when it is empty or its
   // current transaction leaves this cycle.
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign advance  = in_valid_ff && out_free;

   // The input register only holds when it is full and cannot move forward.
   assign req_stall   = in_valid_ff && !out_free;
   assign in_valid_in = req_stall ? in_valid_ff : req_valid;
   assign rsp_valid_in = out_free ? in_valid_ff : rsp_valid_ff;

   lrbs_core u_core (
      .chip_variant (variant_ff),
      .state_cur    (state_ff),
      .mode         (in_mode_ff),
      .address      (in_address_ff),
      .write_data   (in_write_data_ff),
      .open_bus     (in_open_bus_ff),
      .state_nxt    (state_in),
      .read_result  (read_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         variant_ff   <= VARIANT_36;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         if (csr_write_enable) begin
            variant_ff <= csr_write_data;
         end
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_mode_ff       <= req_mode;
         in_address_ff    <= req_address;
         in_write_data_ff <= req_write_data;
         in_open_bus_ff   <= req_open_bus;
      end
      if (advance) begin
         rsp_read_ff  <= read_result;
         rsp_state_ff <= state_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_read_data        = rsp_read_ff.read_data;
   assign rsp_read_is_register = rsp_read_ff.read_is_register;
   assign rsp_prg_bank         = rsp_state_ff.prg_bank;
   assign rsp_chr_bank         = rsp_state_ff.chr_bank;
   assign rsp_mirror_vertical  = rsp_state_ff.mirror;

endmodule

// ----- hdl/lrbs_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bank switcher access decode
// Decodes one bus access for the selected variant and returns the updated
// register state together with the register read value.
// ----------------------------------------------------------------------------
module lrbs_core
   import lrbs_pkg::*;
(
   input  logic [2:0]     chip_variant,
   input  lrbs_state_type state_cur,
   input  logic           mode,
   input  logic [15:0]    address,
   input  logic [7:0]     write_data,
   input  logic [7:0]     open_bus,
   output lrbs_state_type state_nxt,
   output lrbs_read_type  read_result
);

   // Register writes of the 4-bit layout (variants 132 and 173).
   function automatic lrbs_state_type write_narrow(input lrbs_state_type s,
                                                   input logic [1:0] sel,
                                                   input logic [7:0] d);
      lrbs_state_type r;
      r = s;
      unique case (sel)
         SEL_LOAD: begin
            if (s.increment_mode) begin
               r.work_register = {2'b00, s.work_register[3], s.work_register[2:0] + 3'd1};
            end else if (s.invert_flag) begin
               r.work_register = {2'b00, s.input_latch[3], ~s.input_latch[2:0]};
            end else begin
               r.work_register = {2'b00, s.input_latch[3:0]};
            end
         end
         SEL_INVERT: r.invert_flag    = d[0];
         SEL_LATCH:  r.input_latch    = {2'b00, d[3:0]};
         SEL_MODE:   r.increment_mode = d[0];
      endcase
      return r;
   endfunction

   // Register writes of the 6-bit layout (variants 136 and 172).
   function automatic lrbs_state_type write_wide(input lrbs_state_type s,
                                                 input logic [1:0] sel,
                                                 input logic [7:0] d);
      lrbs_state_type r;
      r = s;
      unique case (sel)
         SEL_LOAD: begin
            if (s.increment_mode) begin
               r.work_register = {s.work_register[5:4], s.work_register[3:0] + 4'd1};
            end else if (s.invert_flag) begin
               r.work_register = {s.input_latch[5:4], ~s.input_latch[3:0]};
            end else begin
               r.work_register = s.input_latch;
            end
         end
         SEL_INVERT: r.invert_flag    = d[0];
         SEL_LATCH:  r.input_latch    = d[5:0];
         SEL_MODE:   r.increment_mode = d[0];
      endcase
      return r;
   endfunction

   // Register writes of the 2-bit layout (variant 36), data on bits 5:4.
   function automatic lrbs_state_type write_36(input lrbs_state_type s,
                                               input logic [1:0] sel,
                                               input logic [7:0] d);
      lrbs_state_type r;
      r = s;
      unique case (sel)
         SEL_LOAD: begin
            if (s.increment_mode) begin
               r.work_register = {4'b0000, s.work_register[1:0] + 2'd1};
            end else if (s.invert_flag) begin
               r.work_register = {4'b0000, ~s.input_latch[1:0]};
            end else begin
               r.work_register = {4'b0000, s.input_latch[1:0]};
            end
         end
         SEL_INVERT: r.invert_flag    = d[4];
         SEL_LATCH:  r.input_latch    = {4'b0000, d[5:4]};
         SEL_MODE:   r.increment_mode = d[4];
      endcase
      return r;
   endfunction

   logic       reg_hit;
   logic       chr_hit;
   logic       commit;
   logic [1:0] sel;
   logic [7:0] read_wide;

   assign reg_hit = (address & REG_WINDOW_MASK) == REG_WINDOW;
   assign chr_hit = (address & CHR_WINDOW_MASK) == CHR_WINDOW;
   assign commit  = address[15];
   assign sel     = address[1:0];

   // Read layout shared by variants 136 and 172.
   assign read_wide = {open_bus[7:6],
                       state_cur.invert_flag ? ~state_cur.work_register[5:4]
                                             : state_cur.work_register[5:4],
                       state_cur.work_register[3:0]};

   always_comb begin
      state_nxt   = state_cur;
      read_result = '0;
      unique case (chip_variant)
         VARIANT_36: begin
            if (mode) begin
               if (reg_hit) begin
                  state_nxt = write_36(state_cur, sel, write_data);
               end
               if (chr_hit) begin
                  state_nxt.chr_bank = write_data[3:0];
               end else if (!reg_hit && commit) begin
                  state_nxt.prg_bank = state_cur.work_register[1:0];
               end
            end else if (reg_hit) begin
               read_result.read_is_register = 1'b1;
               read_result.read_data = {open_bus[7:6], state_cur.work_register[1:0],
                                        open_bus[3:0]};
            end
         end
         VARIANT_132, VARIANT_173: begin
            if (mode) begin
               if (reg_hit) begin
                  state_nxt = write_narrow(state_cur, sel, write_data);
               end else if (commit) begin
                  if (chip_variant == VARIANT_132) begin
                     state_nxt.chr_bank = {2'b00, state_cur.work_register[1:0]};
                     state_nxt.prg_bank = {1'b0, state_cur.work_register[2]};
                  end else begin
                     state_nxt.chr_bank = {2'b00, ~state_cur.invert_flag,
                                           state_cur.work_register[0]};
                  end
               end
            end else if (reg_hit && chip_variant == VARIANT_132) begin
               read_result.read_is_register = 1'b1;
               read_result.read_data = {open_bus[7:4],
                                        state_cur.invert_flag ? ~state_cur.work_register[3]
                                                              : state_cur.work_register[3],
                                        state_cur.work_register[2:0]};
            end
         end
         VARIANT_136, VARIANT_172: begin
            if (mode) begin
               if (reg_hit) begin
                  state_nxt = write_wide(state_cur, sel,
                                         (chip_variant == VARIANT_172) ? rev6(write_data)
                                                                       : write_data);
               end else if (commit) begin
                  state_nxt.chr_bank = {2'b00, state_cur.work_register[1:0]};
                  if (chip_variant == VARIANT_172) begin
                     state_nxt.mirror = state_cur.invert_flag;
                  end
               end
            end else if (reg_hit) begin
               read_result.read_is_register = 1'b1;
               read_result.read_data = (chip_variant == VARIANT_172) ? rev6(read_wide)
                                                                     : read_wide;
            end
         end
         default: begin
            // Unassigned variant codes ignore every access.
            state_nxt   = state_cur;
            read_result = '0;
         end
      endcase
   end

endmodule

// ----- hdl/lrbs_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bank switcher port checker
// Concurrent assertions on the top level ports, bound to the top level.
// ----------------------------------------------------------------------------
module lrbs_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [7:0]  rsp_read_data,
   input logic        rsp_read_is_register,
   input logic [1:0]  rsp_prg_bank,
   input logic [3:0]  rsp_chr_bank,
   input logic        rsp_mirror_vertical
);

   // A stalled response holds its transaction.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_read_data) &&
         $stable(rsp_read_is_register) && $stable(rsp_prg_bank) &&
         $stable(rsp_chr_bank) && $stable(rsp_mirror_vertical))
      else $error("response changed while stalled");

   // Requests are only held back when a finished response is waiting.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without a waiting response");

   // Accesses the chip does not answer read as zero.
   a_read_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_read_is_register |-> rsp_read_data == 8'd0)
      else $error("nonzero read data without a register answer");

   // No response is pending right after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind latch_register_bank_switcher_top lrbs_checker u_lrbs_checker (.*);
